// ===== design/eapr_pkg.sv =====
// Shared types, constants and lookup tables for the Euler angle point rotator.
package eapr_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 19;
  localparam int ENTRY_W      = 18;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 19;
  localparam int ENTRY_COUNT  = 9;
  localparam int ENTRY_IDX_W  = 4;

  localparam int ATAN_LEN     = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 17;
  localparam int CORDIC_XY_W  = 33;
  localparam int CORDIC_Z_W   = 20;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int PI_Q16       = 205887;
  localparam int HALF_PI_Q16  = 102944;

  localparam int ENTRY_MAX    = 131071;
  localparam int ENTRY_MIN    = -131072;
  localparam int ONE_Q16      = 65536;

  // scratch store: sin/cos pairs, temporaries, matrix accumulators
  localparam int RF_W         = 20;
  localparam int RF_DEPTH     = 32;
  localparam int RF_ADDR_W    = 5;
  localparam int OPS_PER_MODE = 16;
  localparam int OP_STEP_W    = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_FIRST   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_SECOND  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_THIRD   = 3'd3;

  localparam logic [RF_ADDR_W-1:0] RI_S1  = 5'd0;
  localparam logic [RF_ADDR_W-1:0] RI_C1  = 5'd1;
  localparam logic [RF_ADDR_W-1:0] RI_S2  = 5'd2;
  localparam logic [RF_ADDR_W-1:0] RI_C2  = 5'd3;
  localparam logic [RF_ADDR_W-1:0] RI_S3  = 5'd4;
  localparam logic [RF_ADDR_W-1:0] RI_C3  = 5'd5;
  localparam logic [RF_ADDR_W-1:0] RI_T0  = 5'd6;
  localparam logic [RF_ADDR_W-1:0] RI_T1  = 5'd7;
  localparam logic [RF_ADDR_W-1:0] RI_T2  = 5'd8;
  localparam logic [RF_ADDR_W-1:0] RI_M0  = 5'd9;
  localparam logic [RF_ADDR_W-1:0] RI_M1  = 5'd10;
  localparam logic [RF_ADDR_W-1:0] RI_M2  = 5'd11;
  localparam logic [RF_ADDR_W-1:0] RI_M3  = 5'd12;
  localparam logic [RF_ADDR_W-1:0] RI_M4  = 5'd13;
  localparam logic [RF_ADDR_W-1:0] RI_M5  = 5'd14;
  localparam logic [RF_ADDR_W-1:0] RI_M6  = 5'd15;
  localparam logic [RF_ADDR_W-1:0] RI_M7  = 5'd16;
  localparam logic [RF_ADDR_W-1:0] RI_M8  = 5'd17;
  localparam logic [RF_ADDR_W-1:0] RI_ONE = 5'd18;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t [ENTRY_COUNT-1:0] matrix_t;

  localparam entry_t E_ONE  = 18'sd65536;
  localparam entry_t E_ZERO = 18'sd0;
  localparam matrix_t IDENTITY_MATRIX = {E_ONE, E_ZERO, E_ZERO, E_ZERO, E_ONE,
                                         E_ZERO, E_ZERO, E_ZERO, E_ONE};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;
  } point_out_t;

  typedef enum logic [1:0] {
    MOP_SET,
    MOP_ADD,
    MOP_SUB,
    MOP_NEG
  } mop_kind_t;

  typedef struct packed {
    logic [RF_ADDR_W-1:0] src_a;
    logic [RF_ADDR_W-1:0] src_b;
    logic [RF_ADDR_W-1:0] dst;
    mop_kind_t            kind;
  } mop_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_CORDIC,
    SEQ_WR_SIN,
    SEQ_WR_COS,
    SEQ_OP_READ,
    SEQ_OP_MUL,
    SEQ_OP_WRITE
  } seq_state_t;

  typedef enum logic {
    PH_PROGRAM,
    PH_COPY
  } seq_phase_t;

  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic mop_t mop(input logic [RF_ADDR_W-1:0] a, input logic [RF_ADDR_W-1:0] b,
                               input logic [RF_ADDR_W-1:0] d, input mop_kind_t k);
    mop_t m;
    m.src_a = a;
    m.src_b = b;
    m.dst   = d;
    m.kind  = k;
    return m;
  endfunction

  // matrix build program: upper bit selects the global form
  function automatic mop_t op_lookup(input logic [OP_STEP_W:0] idx);
    mop_t m;
    case (idx)
      5'd0:    m = mop(RI_C3, RI_C1,  RI_T0, MOP_SET);
      5'd1:    m = mop(RI_S3, RI_C2,  RI_T1, MOP_SET);
      5'd2:    m = mop(RI_S3, RI_S2,  RI_T2, MOP_SET);
      5'd3:    m = mop(RI_T0, RI_C2,  RI_M0, MOP_SET);
      5'd4:    m = mop(RI_T2, RI_ONE, RI_M0, MOP_SUB);
      5'd5:    m = mop(RI_T1, RI_C1,  RI_M3, MOP_SET);
      5'd6:    m = mop(RI_C3, RI_S2,  RI_M3, MOP_ADD);
      5'd7:    m = mop(RI_S1, RI_C2,  RI_M6, MOP_NEG);
      5'd8:    m = mop(RI_T0, RI_S2,  RI_M1, MOP_NEG);
      5'd9:    m = mop(RI_T1, RI_ONE, RI_M1, MOP_SUB);
      5'd10:   m = mop(RI_C3, RI_C2,  RI_M4, MOP_SET);
      5'd11:   m = mop(RI_T2, RI_C1,  RI_M4, MOP_SUB);
      5'd12:   m = mop(RI_S1, RI_S2,  RI_M7, MOP_SET);
      5'd13:   m = mop(RI_C3, RI_S1,  RI_M2, MOP_SET);
      5'd14:   m = mop(RI_S3, RI_S1,  RI_M5, MOP_SET);
      5'd15:   m = mop(RI_C1, RI_ONE, RI_M8, MOP_SET);
      5'd16:   m = mop(RI_S1, RI_S2,  RI_T0, MOP_SET);
      5'd17:   m = mop(RI_C1, RI_S2,  RI_T1, MOP_SET);
      5'd18:   m = mop(RI_C2, RI_C3,  RI_M0, MOP_SET);
      5'd19:   m = mop(RI_T0, RI_C3,  RI_M3, MOP_SET);
      5'd20:   m = mop(RI_C1, RI_S3,  RI_M3, MOP_ADD);
      5'd21:   m = mop(RI_T1, RI_C3,  RI_M6, MOP_NEG);
      5'd22:   m = mop(RI_S1, RI_S3,  RI_M6, MOP_ADD);
      5'd23:   m = mop(RI_C2, RI_S3,  RI_M1, MOP_NEG);
      5'd24:   m = mop(RI_T0, RI_S3,  RI_M4, MOP_NEG);
      5'd25:   m = mop(RI_C1, RI_C3,  RI_M4, MOP_ADD);
      5'd26:   m = mop(RI_T1, RI_S3,  RI_M7, MOP_SET);
      5'd27:   m = mop(RI_S1, RI_C3,  RI_M7, MOP_ADD);
      5'd28:   m = mop(RI_S2, RI_ONE, RI_M2, MOP_SET);
      5'd29:   m = mop(RI_S1, RI_C2,  RI_M5, MOP_NEG);
      5'd30:   m = mop(RI_C1, RI_C2,  RI_M8, MOP_SET);
      default: m = mop(RI_C1, RI_C2,  RI_M8, MOP_SET);
    endcase
    return m;
  endfunction

endpackage

// ===== design/eapr_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module eapr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== design/eapr_cordic.sv =====
// Iterative rotation-mode CORDIC giving Q.16 sine and cosine of one angle.
module eapr_cordic #(
  parameter int ITERS = 18
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [eapr_pkg::ANGLE_W-1:0]  angle,
  output logic                                 done,
  output logic signed [eapr_pkg::ENTRY_W-1:0] sin_q16,
  output logic signed [eapr_pkg::ENTRY_W-1:0] cos_q16
);

  localparam int XY_W = eapr_pkg::CORDIC_XY_W;
  localparam int Z_W  = eapr_pkg::CORDIC_Z_W;
  localparam logic [eapr_pkg::ATAN_IDX_W-1:0] LAST_STEP = eapr_pkg::ATAN_IDX_W'(ITERS - 1);
  localparam logic signed [Z_W-1:0]  PI_Z      = Z_W'(eapr_pkg::PI_Q16);
  localparam logic signed [Z_W-1:0]  HALF_PI_Z = Z_W'(eapr_pkg::HALF_PI_Q16);
  localparam logic signed [XY_W-1:0] GAIN_XY   = XY_W'(eapr_pkg::CORDIC_GAIN);
  localparam logic signed [XY_W-1:0] ROUND_XY  = 33'sd8192;

  logic                                   running;
  logic [eapr_pkg::ATAN_IDX_W-1:0]        step;
  logic signed [XY_W-1:0]                 x, y, x_next, y_next, xs, ys, x_rnd, y_rnd;
  logic signed [Z_W-1:0]                  z, z_next, z_init, z_raw, atan_z;
  logic                                   flip, flip_init;

  always_comb begin
    z_raw     = {angle[eapr_pkg::ANGLE_W-1], angle};
    z_init    = z_raw;
    flip_init = 1'b0;
    if (z_raw > HALF_PI_Z) begin
      z_init    = z_raw - PI_Z;
      flip_init = 1'b1;
    end else if (z_raw < -HALF_PI_Z) begin
      z_init    = z_raw + PI_Z;
      flip_init = 1'b1;
    end
  end

  always_comb begin
    xs     = x >>> step;
    ys     = y >>> step;
    atan_z = {3'b000, eapr_pkg::atan_q16(step)};
    if (z >= 0) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan_z;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
        x       <= GAIN_XY;
        y       <= '0;
        z       <= z_init;
        flip    <= flip_init;
      end else if (running) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign x_rnd   = (x + ROUND_XY) >>> 14;
  assign y_rnd   = (y + ROUND_XY) >>> 14;
  assign cos_q16 = flip ? -x_rnd[eapr_pkg::ENTRY_W-1:0] : x_rnd[eapr_pkg::ENTRY_W-1:0];
  assign sin_q16 = flip ? -y_rnd[eapr_pkg::ENTRY_W-1:0] : y_rnd[eapr_pkg::ENTRY_W-1:0];

endmodule

// ===== design/eapr_matrix.sv =====
// Configuration registers and the sequencer that rebuilds the rotation matrix.
module eapr_matrix #(
  parameter int ITERS = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [eapr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [eapr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                busy,
  output eapr_pkg::matrix_t                   entries
);

  localparam int RF_W = eapr_pkg::RF_W;
  localparam int AW   = eapr_pkg::RF_ADDR_W;
  localparam logic signed [2*RF_W-1:0] ROUND_Q16 = 40'sd32768;
  localparam logic signed [RF_W-1:0]   ONE_RF    = RF_W'(eapr_pkg::ONE_Q16);
  localparam logic signed [RF_W-1:0]   MAX_RF    = RF_W'(eapr_pkg::ENTRY_MAX);
  localparam logic signed [RF_W-1:0]   MIN_RF    = RF_W'(eapr_pkg::ENTRY_MIN);
  localparam logic [eapr_pkg::OP_STEP_W-1:0]   LAST_OP   =
    eapr_pkg::OP_STEP_W'(eapr_pkg::OPS_PER_MODE - 1);
  localparam logic [eapr_pkg::ENTRY_IDX_W-1:0] LAST_COPY =
    eapr_pkg::ENTRY_IDX_W'(eapr_pkg::ENTRY_COUNT);

  logic                                     rotation_mode;
  logic signed [eapr_pkg::ANGLE_W-1:0]      angle_first, angle_second, angle_third;
  logic                                     cfg_hit;

  eapr_pkg::seq_state_t                     state, state_next;
  eapr_pkg::seq_phase_t                     phase, phase_next;
  logic [1:0]                               sel, sel_next;
  logic [eapr_pkg::OP_STEP_W-1:0]           step, step_next;
  logic [eapr_pkg::ENTRY_IDX_W-1:0]         copy_idx, copy_idx_next, copy_prev;
  logic                                     copy_wr;
  logic signed [RF_W-1:0]                   prod, prod_next;
  eapr_pkg::mop_t                           op;

  logic                                     cordic_start, cordic_done;
  logic signed [eapr_pkg::ANGLE_W-1:0]      cordic_angle;
  logic signed [eapr_pkg::ENTRY_W-1:0]      sin_q16, cos_q16;

  logic                                     wr_en;
  logic [AW-1:0]                            wr_addr, rd_addr_a, rd_addr_b;
  logic [RF_W-1:0]                          wr_data, rd_data_a, rd_data_b;
  logic signed [RF_W-1:0]                   opa, opb, old_val, combined, copy_val;
  logic signed [2*RF_W-1:0]                 prod_full, prod_rnd;
  eapr_pkg::entry_t                         copy_clamped;

  assign cfg_hit = cfg_we && (cfg_index <= eapr_pkg::REG_ANGLE_THIRD);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode <= 1'b0;
      angle_first   <= '0;
      angle_second  <= '0;
      angle_third   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        eapr_pkg::REG_ROTATION_MODE: rotation_mode <= cfg_data[0];
        eapr_pkg::REG_ANGLE_FIRST:   angle_first   <= cfg_data;
        eapr_pkg::REG_ANGLE_SECOND:  angle_second  <= cfg_data;
        eapr_pkg::REG_ANGLE_THIRD:   angle_third   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      2'd0:    cordic_angle = angle_first;
      2'd1:    cordic_angle = angle_second;
      default: cordic_angle = angle_third;
    endcase
  end

  eapr_cordic #(.ITERS(ITERS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .done    (cordic_done),
    .sin_q16 (sin_q16),
    .cos_q16 (cos_q16)
  );

  eapr_ram #(.WIDTH(RF_W), .DEPTH(eapr_pkg::RF_DEPTH)) u_scratch (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  assign op = eapr_pkg::op_lookup({rotation_mode, step});

  // product of two Q.16 values, rounded half up
  always_comb begin
    opa       = (op.src_a == eapr_pkg::RI_ONE) ? ONE_RF : $signed(rd_data_a);
    opb       = (op.src_b == eapr_pkg::RI_ONE) ? ONE_RF : $signed(rd_data_b);
    prod_full = opa * opb;
    prod_rnd  = (prod_full + ROUND_Q16) >>> 16;
    old_val   = $signed(rd_data_a);
    case (op.kind)
      eapr_pkg::MOP_SET: combined = prod;
      eapr_pkg::MOP_ADD: combined = old_val + prod;
      eapr_pkg::MOP_SUB: combined = old_val - prod;
      eapr_pkg::MOP_NEG: combined = -prod;
      default:           combined = prod;
    endcase
  end

  always_comb begin
    copy_val = $signed(rd_data_a);
    if (copy_val > MAX_RF) begin
      copy_clamped = MAX_RF[eapr_pkg::ENTRY_W-1:0];
    end else if (copy_val < MIN_RF) begin
      copy_clamped = MIN_RF[eapr_pkg::ENTRY_W-1:0];
    end else begin
      copy_clamped = copy_val[eapr_pkg::ENTRY_W-1:0];
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    sel_next      = sel;
    step_next     = step;
    copy_idx_next = copy_idx;
    prod_next     = prod;
    cordic_start  = 1'b0;
    copy_wr       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = op.dst;
    wr_data       = combined;
    rd_addr_a     = op.src_a;
    rd_addr_b     = op.src_b;
    case (state)
      eapr_pkg::SEQ_IDLE: begin
      end
      eapr_pkg::SEQ_START: begin
        cordic_start = 1'b1;
        state_next   = eapr_pkg::SEQ_CORDIC;
      end
      eapr_pkg::SEQ_CORDIC: begin
        if (cordic_done) begin
          state_next = eapr_pkg::SEQ_WR_SIN;
        end
      end
      eapr_pkg::SEQ_WR_SIN: begin
        wr_en      = 1'b1;
        wr_addr    = AW'({sel, 1'b0});
        wr_data    = {{(RF_W - eapr_pkg::ENTRY_W){sin_q16[eapr_pkg::ENTRY_W-1]}}, sin_q16};
        state_next = eapr_pkg::SEQ_WR_COS;
      end
      eapr_pkg::SEQ_WR_COS: begin
        wr_en   = 1'b1;
        wr_addr = AW'({sel, 1'b1});
        wr_data = {{(RF_W - eapr_pkg::ENTRY_W){cos_q16[eapr_pkg::ENTRY_W-1]}}, cos_q16};
        if (sel == 2'd2) begin
          sel_next   = 2'd0;
          step_next  = '0;
          phase_next = eapr_pkg::PH_PROGRAM;
          state_next = eapr_pkg::SEQ_OP_READ;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = eapr_pkg::SEQ_START;
        end
      end
      eapr_pkg::SEQ_OP_READ: begin
        if (phase == eapr_pkg::PH_COPY) begin
          // copy sweep: read accumulator, clamp into the entry in the next cycle
          rd_addr_a     = eapr_pkg::RI_M0 + AW'(copy_idx);
          copy_wr       = (copy_idx != '0);
          copy_idx_next = copy_idx + 1'b1;
          if (copy_idx == LAST_COPY) begin
            state_next = eapr_pkg::SEQ_IDLE;
          end
        end else begin
          state_next = eapr_pkg::SEQ_OP_MUL;
        end
      end
      eapr_pkg::SEQ_OP_MUL: begin
        prod_next  = prod_rnd[RF_W-1:0];
        rd_addr_a  = op.dst;
        state_next = eapr_pkg::SEQ_OP_WRITE;
      end
      eapr_pkg::SEQ_OP_WRITE: begin
        wr_en      = 1'b1;
        step_next  = step + 1'b1;
        state_next = eapr_pkg::SEQ_OP_READ;
        if (step == LAST_OP) begin
          phase_next    = eapr_pkg::PH_COPY;
          copy_idx_next = '0;
        end
      end
      default: begin
        state_next = eapr_pkg::SEQ_IDLE;
      end
    endcase
    if (cfg_hit) begin
      state_next = eapr_pkg::SEQ_START;
      sel_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= eapr_pkg::SEQ_IDLE;
      phase    <= eapr_pkg::PH_PROGRAM;
      sel      <= 2'd0;
      step     <= '0;
      copy_idx <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      sel      <= sel_next;
      step     <= step_next;
      copy_idx <= copy_idx_next;
    end
    prod <= prod_next;
  end

  assign copy_prev = copy_idx - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= eapr_pkg::IDENTITY_MATRIX;
    end else if (copy_wr) begin
      entries[copy_prev] <= copy_clamped;
    end
  end

  assign busy = (state != eapr_pkg::SEQ_IDLE);

endmodule

// ===== design/eapr_transform.sv =====
// Three-stage elastic pipeline applying the 3x3 matrix to one point per cycle while out_ready allows.
module eapr_transform (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  eapr_pkg::point_in_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eapr_pkg::point_out_t  out_data,
  input  eapr_pkg::matrix_t     entries
);

  localparam int PROD_W = eapr_pkg::COORD_W + eapr_pkg::ENTRY_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] ROUND_Q16 = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] OUT_MAX   = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] OUT_MIN   = -(SUM_W'(2147483647)) - SUM_W'(1);

  logic                       v1, v2, v3, r1, r2, r3;
  eapr_pkg::point_in_t        pt;
  logic signed [PROD_W-1:0]   prod [eapr_pkg::ENTRY_COUNT];
  logic signed [PROD_W-1:0]   prod_next [eapr_pkg::ENTRY_COUNT];
  logic signed [SUM_W-1:0]    sum [3];
  logic signed [SUM_W-1:0]    scaled [3];
  logic signed [eapr_pkg::COORD_W-1:0] sat [3];

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_next[r*3]     = pt.point_x * $signed(entries[r*3]);
      prod_next[r*3 + 1] = pt.point_y * $signed(entries[r*3 + 1]);
      prod_next[r*3 + 2] = pt.point_z * $signed(entries[r*3 + 2]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r]    = SUM_W'(prod[r*3]) + SUM_W'(prod[r*3 + 1]) + SUM_W'(prod[r*3 + 2]);
      scaled[r] = (sum[r] + ROUND_Q16) >>> 16;
      if (scaled[r] > OUT_MAX) begin
        sat[r] = OUT_MAX[eapr_pkg::COORD_W-1:0];
      end else if (scaled[r] < OUT_MIN) begin
        sat[r] = OUT_MIN[eapr_pkg::COORD_W-1:0];
      end else begin
        sat[r] = scaled[r][eapr_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
    if (r1 && in_valid) begin
      pt <= in_data;
    end
    if (r2 && v1) begin
      prod <= prod_next;
    end
    if (r3 && v2) begin
      out_data.rotated_x <= sat[0];
      out_data.rotated_y <= sat[1];
      out_data.rotated_z <= sat[2];
    end
  end

  assign out_valid = v3;

endmodule

// ===== design/euler_angle_point_rotator.sv =====
// Top level of the Euler angle point rotator.
//
// Rotates Q15.16 points by a 3x3 Q1.16 matrix built from three angles, one
// point per clock unless the output stalls or the matrix is being rebuilt.
// Each result passes the input register, the multiply stage (nine 32x18
// products) and the add/round/saturate result register. A write to one of
// the four configuration registers rebuilds the matrix: three CORDIC runs on
// one shared unit, sixteen multiply-accumulate steps through a scratch RAM
// and a nine-entry copy, during which in_ready stays low. A further write to
// one of them restarts the rebuild. Writes to indexes beyond the register
// list are ignored.
module euler_angle_point_rotator #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  eapr_pkg::point_in_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output eapr_pkg::point_out_t              out_data,
  input  logic                              cfg_we,
  input  logic [eapr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [eapr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CORDIC_ITERS =
    (CORDIC_STEPS > eapr_pkg::ATAN_LEN) ? eapr_pkg::ATAN_LEN : CORDIC_STEPS;

  logic              busy;
  logic              hold;
  logic              pipe_ready;
  eapr_pkg::matrix_t entries;

  assign hold     = busy || cfg_we;
  assign in_ready = pipe_ready && !hold;

  eapr_matrix #(.ITERS(CORDIC_ITERS)) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .entries   (entries)
  );

  eapr_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid && !hold),
    .in_ready  (pipe_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .entries   (entries)
  );

endmodule

// ===== design/eapr_checker.sv =====
// Port-level checks for the Euler angle point rotator, bound to the top level.
module eapr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input eapr_pkg::point_in_t               in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input eapr_pkg::point_out_t              out_data,
  input logic                              cfg_we,
  input logic [eapr_pkg::CFG_INDEX_W-1:0]  cfg_index
);

  // waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item dropped or changed while waiting");

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item dropped or changed while stalled");

  a_cfg_blocks_input: assert property (@(posedge clk)
    cfg_we |-> !in_ready)
    else $error("item accepted during a configuration write");

  a_rebuild_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index <= eapr_pkg::REG_ANGLE_THIRD) |=> !in_ready)
    else $error("item accepted while the matrix is being rebuilt");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind euler_angle_point_rotator eapr_checker u_checker (.*);

// ===== tb/tb_euler_angle_point_rotator.sv =====
// Testbench for euler_angle_point_rotator: predicts each rotated point from the angle registers.
module tb_euler_angle_point_rotator;
  import eapr_pkg::*;

  localparam int CORDIC_ITERS = 18;
  localparam int ITERS_USED   = (CORDIC_ITERS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERS;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    point_in_t pt;
    logic      drain_first;
  } send_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  point_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  point_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the configuration and the matrix it gives
  logic                   mode_q;
  logic [ANGLE_W-1:0]     ang1_q, ang2_q, ang3_q;
  longint                 rot_m [9];

  send_item_t points_to_send [$];
  point_out_t rotated_due [$];
  int         error_count = 0;
  int         results_seen = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         long_hold_done = 0;
  bit         quiet = 0;
  send_item_t next_item;
  point_out_t want;

  euler_angle_point_rotator #(.CORDIC_STEPS(CORDIC_ITERS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint atan_step(input int i);
    case (i)
      0: return 51472;   1: return 30386;   2: return 16055;   3: return 8150;
      4: return 4091;    5: return 2047;    6: return 1024;    7: return 512;
      8: return 256;     9: return 128;     10: return 64;     11: return 32;
      12: return 16;     13: return 8;      14: return 4;      15: return 2;
      16: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint q16_mul(input longint a, input longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic void cordic_sin_cos(input logic [ANGLE_W-1:0] raw,
                                         output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    int i;
    z = longint'($signed(raw));
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    // fold into the CORDIC's convergence range, negate afterwards
    if (z > HALF_PI_Q16) begin
      z -= PI_Q16;
      flip = 1;
    end else if (z < -HALF_PI_Q16) begin
      z += PI_Q16;
      flip = 1;
    end
    for (i = 0; i < ITERS_USED; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_step(i);
      end else begin
        x += ys;
        y -= xs;
        z += atan_step(i);
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic void build_rotation();
    longint s1, c1, s2, c2, s3, c3, t0, t1, t2;
    longint m [9];
    int k;
    cordic_sin_cos(ang1_q, s1, c1);
    cordic_sin_cos(ang2_q, s2, c2);
    cordic_sin_cos(ang3_q, s3, c3);
    if (!mode_q) begin
      t0 = q16_mul(c3, c1);
      t1 = q16_mul(s3, c2);
      t2 = q16_mul(s3, s2);
      m[0] = q16_mul(t0, c2) - t2;
      m[3] = q16_mul(t1, c1) + q16_mul(c3, s2);
      m[6] = -q16_mul(s1, c2);
      m[1] = -(q16_mul(t0, s2) + t1);
      m[4] = q16_mul(c3, c2) - q16_mul(t2, c1);
      m[7] = q16_mul(s1, s2);
      m[2] = q16_mul(c3, s1);
      m[5] = q16_mul(s3, s1);
      m[8] = c1;
    end else begin
      t0 = q16_mul(s1, s2);
      t1 = q16_mul(c1, s2);
      m[0] = q16_mul(c2, c3);
      m[3] = q16_mul(t0, c3) + q16_mul(c1, s3);
      m[6] = -q16_mul(t1, c3) + q16_mul(s1, s3);
      m[1] = -q16_mul(c2, s3);
      m[4] = -q16_mul(t0, s3) + q16_mul(c1, c3);
      m[7] = q16_mul(t1, s3) + q16_mul(s1, c3);
      m[2] = s2;
      m[5] = -q16_mul(s1, c2);
      m[8] = q16_mul(c1, c2);
    end
    for (k = 0; k < 9; k++) begin
      if (m[k] > ENTRY_MAX) rot_m[k] = ENTRY_MAX;
      else if (m[k] < ENTRY_MIN) rot_m[k] = ENTRY_MIN;
      else rot_m[k] = m[k];
    end
  endfunction

  function automatic point_out_t rotate_point(input point_in_t p);
    longint v [3];
    longint acc;
    logic signed [COORD_W-1:0] o [3];
    point_out_t r;
    int k;
    v[0] = p.point_x;
    v[1] = p.point_y;
    v[2] = p.point_z;
    for (k = 0; k < 3; k++) begin
      acc = v[0] * rot_m[3*k] + v[1] * rot_m[3*k+1] + v[2] * rot_m[3*k+2];
      acc = (acc + 32768) >>> 16;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      o[k] = acc[COORD_W-1:0];
    end
    r.rotated_x = o[0];
    r.rotated_y = o[1];
    r.rotated_z = o[2];
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] q16_angle(input int a);
    return a[CFG_DATA_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_angle();
    int a;
    case ($urandom_range(0, 5))
      0: a = $urandom_range(0, 1) ? PI_Q16 : -PI_Q16;
      1: a = ($urandom_range(0, 1) ? 1 : -1) * (HALF_PI_Q16 + int'($urandom_range(0, 1)));
      default: a = int'($urandom_range(0, 2 * PI_Q16)) - PI_Q16;
    endcase
    return q16_angle(a);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(exp_v), $realtime);
    error_count++;
  endtask

  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROTATION_MODE: mode_q = val[0];
      REG_ANGLE_FIRST:   ang1_q = val[ANGLE_W-1:0];
      REG_ANGLE_SECOND:  ang2_q = val[ANGLE_W-1:0];
      REG_ANGLE_THIRD:   ang3_q = val[ANGLE_W-1:0];
      default: return;
    endcase
    build_rotation();
  endtask

  task automatic queue_xyz(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input bit drain);
    send_item_t it;
    it.pt.point_x = x;
    it.pt.point_y = y;
    it.pt.point_z = z;
    it.drain_first = drain;
    points_to_send = {points_to_send, it};
  endtask

  task automatic wait_idle();
    while (points_to_send.size() != 0 || in_valid || rotated_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        rotated_due = {rotated_due, rotate_point(in_data)};
        if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 13);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (points_to_send.size() != 0 &&
                     !(points_to_send[0].drain_first && rotated_due.size() != 0)) begin
          next_item = points_to_send.pop_front();
          in_valid <= 1'b1;
          in_data <= next_item.pt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (rotated_due.size() == 0) begin
          report_mismatch("unexpected item", out_data.rotated_x, '0);
        end else begin
          want = rotated_due.pop_front();
          if (out_data.rotated_x !== want.rotated_x)
            report_mismatch("rotated_x", out_data.rotated_x, want.rotated_x);
          if (out_data.rotated_y !== want.rotated_y)
            report_mismatch("rotated_y", out_data.rotated_y, want.rotated_y);
          if (out_data.rotated_z !== want.rotated_z)
            report_mismatch("rotated_z", out_data.rotated_z, want.rotated_z);
        end
      end
      // one long hold-off so the pipeline backs up into the input
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1;
        stall_left = 90;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int ph, n;
    mode_q = 1'b0;
    ang1_q = '0;
    ang2_q = '0;
    ang3_q = '0;
    for (n = 0; n < 9; n++) rot_m[n] = (n % 4 == 0) ? ONE_Q16 : 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // identity matrix straight out of reset
    @(negedge clk);
    queue_xyz(32'h0, 32'h0, 32'h0, 0);
    queue_xyz(32'h7FFFFFFF, 32'h80000000, 32'h1, 0);
    queue_xyz(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0);
    queue_xyz(32'h00010000, 32'hFFFF0000, 32'h00008000, 0);
    queue_xyz(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    wait_idle();

    // global form, angles at plus and minus pi and exactly pi/2
    program_reg(REG_ROTATION_MODE, 19'd1);
    program_reg(REG_ANGLE_FIRST, q16_angle(PI_Q16));
    program_reg(REG_ANGLE_SECOND, q16_angle(-PI_Q16));
    program_reg(REG_ANGLE_THIRD, q16_angle(HALF_PI_Q16));
    @(negedge clk);
    queue_xyz(32'h00010000, 32'h0, 32'h0, 0);
    queue_xyz(32'h0, 32'h00010000, 32'h0, 0);
    queue_xyz(32'h0, 32'h0, 32'h00010000, 0);
    queue_xyz(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    wait_idle();

    // local form, just past pi/2 both ways
    program_reg(REG_ROTATION_MODE, 19'd0);
    program_reg(REG_ANGLE_FIRST, q16_angle(HALF_PI_Q16 + 1));
    program_reg(REG_ANGLE_SECOND, q16_angle(-HALF_PI_Q16 - 1));
    program_reg(REG_ANGLE_THIRD, q16_angle(-HALF_PI_Q16));
    @(negedge clk);
    queue_xyz(32'h00010000, 32'h00010000, 32'h00010000, 0);
    queue_xyz(32'hFFFF0000, 32'h00020000, 32'h12345678, 0);
    queue_xyz(32'h80000000, 32'h0, 32'h7FFFFFFF, 0);
    wait_idle();

    // quarter-pi angles so sums saturate; spare indexes must change nothing
    program_reg(REG_ANGLE_FIRST, q16_angle(51472));
    program_reg(REG_ANGLE_SECOND, q16_angle(51472));
    program_reg(REG_ANGLE_THIRD, q16_angle(HALF_PI_Q16));
    program_reg(REG_SPARE_LO, pick_angle());
    program_reg(REG_SPARE_HI, 19'h7FFFF);
    @(negedge clk);
    queue_xyz(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    queue_xyz(32'h80000000, 32'h80000000, 32'h80000000, 0);
    queue_xyz(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    queue_xyz(32'h80000000, 32'h7FFFFFFF, 32'h0, 1);
    wait_idle();

    for (ph = 0; ph < 12; ph++) begin
      if (ph >= 10) quiet = 1;
      if (ph == 0 || $urandom_range(0, 2) == 0)
        program_reg(REG_ROTATION_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) program_reg(REG_ANGLE_FIRST, pick_angle());
      if ($urandom_range(0, 2) != 0) program_reg(REG_ANGLE_SECOND, pick_angle());
      if ($urandom_range(0, 2) != 0) program_reg(REG_ANGLE_THIRD, pick_angle());
      if ($urandom_range(0, 5) == 0)
        program_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, pick_angle());
      @(negedge clk);
      for (n = 0; n < 100; n++)
        queue_xyz(pick_coord(), pick_coord(), pick_coord(),
                  !quiet && $urandom_range(0, 59) == 0);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/eapr_pkg.sv
design/eapr_ram.sv
design/eapr_cordic.sv
design/eapr_matrix.sv
design/eapr_transform.sv
design/euler_angle_point_rotator.sv
design/eapr_checker.sv
tb/tb_euler_angle_point_rotator.sv
